// ===== rtl/mlfd_pkg.sv =====
// Shared types, constants and the segment decode table for the meter LCD frame decoder.
`default_nettype none

package mlfd_pkg;

  localparam int unsigned FrameLen  = 8;   // bytes stored before the checksum byte
  localparam int unsigned NumDigits = 4;

  localparam logic [3:0] CountFull = 4'(FrameLen);
  localparam logic [3:0] CountMax  = 4'd15;
  localparam logic [4:0] SymBlank   = 5'd22;
  localparam logic [4:0] SymUnknown = 5'd31;
  localparam logic [7:0] ContMode   = 8'd20;
  localparam logic [7:0] CsumBias   = 8'd57;
  localparam logic [7:0] SegMask    = 8'hF7;  // drop the decimal-point segment
  localparam logic [19:0] DigitsBlank = {NumDigits{SymBlank}};

  // Input stage plus frame capture state, as seen by the decode stage
  typedef struct packed {
    logic            valid;
    logic            last;
    logic [7:0]      data;
    logic [3:0]      count;
    logic [7:0]      sum;
    logic [7:0][7:0] bytes;
  } frame_t;

  typedef struct packed {
    logic [7:0]  mode_code;
    logic [7:0]  unit_flags;
    logic [7:0]  range_flags;
    logic [7:0]  status_flags;
    logic [19:0] digit_codes;
    logic [2:0]  point_position;
    logic        max_flag;
    logic        checksum_ok;
    logic        continuity;
    logic        kind_changed;
    logic        length_ok;
    logic        digit_error;
  } result_t;

  // Seven-segment pattern to symbol code; unknown patterns give SymUnknown
  function automatic logic [4:0] seg_symbol(input logic [7:0] pat);
    logic [4:0] sym;
    case (pat & SegMask)
      8'd215:  sym = 5'd0;
      8'd80:   sym = 5'd1;
      8'd181:  sym = 5'd2;
      8'd241:  sym = 5'd3;
      8'd114:  sym = 5'd4;
      8'd227:  sym = 5'd5;
      8'd231:  sym = 5'd6;
      8'd81:   sym = 5'd7;
      8'd247:  sym = 5'd8;
      8'd243:  sym = 5'd9;
      8'd39:   sym = 5'd10;
      8'd55:   sym = 5'd11;
      8'd167:  sym = 5'd12;
      8'd135:  sym = 5'd13;
      8'd134:  sym = 5'd14;
      8'd118:  sym = 5'd15;
      8'd6:    sym = 5'd16;
      8'd102:  sym = 5'd17;
      8'd36:   sym = 5'd18;
      8'd166:  sym = 5'd19;
      8'd100:  sym = 5'd20;
      8'd32:   sym = 5'd21;
      8'd0:    sym = SymBlank;
      default: sym = SymUnknown;
    endcase
    return sym;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mlfd_if.sv =====
// Valid/ready channel interfaces for the byte input and the decoded frame output.
`default_nettype none

interface mlfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mlfd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  mode_code;
  logic [7:0]  unit_flags;
  logic [7:0]  range_flags;
  logic [7:0]  status_flags;
  logic [19:0] digit_codes;
  logic [2:0]  point_position;
  logic        max_flag;
  logic        checksum_ok;
  logic        continuity;
  logic        kind_changed;
  logic        length_ok;
  logic        digit_error;

  modport source (
    output valid, output mode_code, output unit_flags, output range_flags,
    output status_flags, output digit_codes, output point_position, output max_flag,
    output checksum_ok, output continuity, output kind_changed, output length_ok,
    output digit_error, input ready
  );
  modport sink (
    input valid, input mode_code, input unit_flags, input range_flags,
    input status_flags, input digit_codes, input point_position, input max_flag,
    input checksum_ok, input continuity, input kind_changed, input length_ok,
    input digit_error, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/mlfd_capture.sv =====
// Input word register, byte counter, running sum and frame byte storage.
`default_nettype none

module mlfd_capture
  import mlfd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mlfd_in_if.sink    in_i,
  input  wire logic  advance_i,
  output frame_t     frame_o
);

  logic            valid_q, valid_d;
  logic            last_q;
  logic [7:0]      data_q;
  logic [3:0]      count_q, count_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0][7:0] bytes_q;
  logic            accept;
  logic            store;

  assign in_i.ready = !valid_q || advance_i;
  assign accept     = in_i.valid && in_i.ready;
  // bytes past the eighth are neither stored nor summed
  assign store      = advance_i && !last_q && (count_q < CountFull);

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end

    count_d = count_q;
    sum_d   = sum_q;
    if (advance_i) begin
      if (last_q) begin
        count_d = '0;
        sum_d   = '0;
      end else begin
        if (store) begin
          sum_d = sum_q + data_q;
        end
        if (count_q != CountMax) begin
          count_d = count_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_i.data_byte;
      last_q <= in_i.last_byte;
    end
    if (store) begin
      bytes_q[count_q[2:0]] <= data_q;
    end
  end

  assign frame_o.valid = valid_q;
  assign frame_o.last  = last_q;
  assign frame_o.data  = data_q;
  assign frame_o.count = count_q;
  assign frame_o.sum   = sum_q;
  assign frame_o.bytes = bytes_q;

endmodule

`default_nettype wire

// ===== rtl/mlfd_decode.sv =====
// Frame decode on the final word, history state and the result register.
`default_nettype none

module mlfd_decode
  import mlfd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  frame_t     frame_i,
  output logic       advance_o,
  mlfd_out_if.source out_o
);

  logic        out_valid_q, out_valid_d;
  result_t     res_q, res_d;
  logic [7:0]  mode_q;
  logic [19:0] digits_q;
  logic [8:0]  kind_q;
  logic [8:0]  kind;
  logic        out_free;
  logic        finish;
  logic        len_ok;
  logic [19:0] digs;
  logic [7:0]  mode_new;

  assign out_free  = !out_valid_q || out_o.ready;
  // a non-final word never produces a result, so it never waits on the output
  assign advance_o = frame_i.valid && (!frame_i.last || out_free);
  assign finish    = advance_o && frame_i.last;
  assign len_ok    = (frame_i.count == CountFull);

  always_comb begin
    for (int k = 0; k < NumDigits; k++) begin
      digs[5*k +: 5] = seg_symbol(frame_i.bytes[3 + k]);
    end
    mode_new = len_ok ? frame_i.bytes[0] : mode_q;

    res_d = '0;
    res_d.mode_code  = mode_new;
    res_d.digit_codes = len_ok ? digs : digits_q;
    res_d.length_ok  = len_ok;
    res_d.continuity = (mode_new == ContMode);
    if (len_ok) begin
      res_d.unit_flags     = frame_i.bytes[1];
      res_d.range_flags    = frame_i.bytes[2];
      res_d.status_flags   = frame_i.bytes[7];
      res_d.point_position = 3'(frame_i.bytes[3][3])
                           + {1'b0, frame_i.bytes[4][3], 1'b0}
                           + (frame_i.bytes[5][3] ? 3'd3 : 3'd0);
      res_d.max_flag       = frame_i.bytes[6][3];
      res_d.checksum_ok    = (frame_i.data == frame_i.sum + CsumBias);
      res_d.digit_error    = (digs[4:0] == SymUnknown) || (digs[9:5] == SymUnknown)
                           || (digs[14:10] == SymUnknown) || (digs[19:15] == SymUnknown);
    end

    kind = {res_d.unit_flags[1], res_d.unit_flags[6], res_d.unit_flags[7],
            res_d.range_flags[2], res_d.status_flags[2], res_d.status_flags[6],
            res_d.unit_flags[3], res_d.range_flags[5], res_d.unit_flags[2]};
    res_d.kind_changed = (kind != kind_q);

    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mode_q      <= '0;
      digits_q    <= DigitsBlank;
      kind_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (finish) begin
        mode_q   <= mode_new;
        digits_q <= res_d.digit_codes;
        kind_q   <= kind;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.mode_code      = res_q.mode_code;
  assign out_o.unit_flags     = res_q.unit_flags;
  assign out_o.range_flags    = res_q.range_flags;
  assign out_o.status_flags   = res_q.status_flags;
  assign out_o.digit_codes    = res_q.digit_codes;
  assign out_o.point_position = res_q.point_position;
  assign out_o.max_flag       = res_q.max_flag;
  assign out_o.checksum_ok    = res_q.checksum_ok;
  assign out_o.continuity     = res_q.continuity;
  assign out_o.kind_changed   = res_q.kind_changed;
  assign out_o.length_ok      = res_q.length_ok;
  assign out_o.digit_error    = res_q.digit_error;

endmodule

`default_nettype wire

// ===== rtl/meter_lcd_frame_decoder.sv =====
// Meter LCD frame decoder: top level joining byte capture and frame decode.
//
// Usage: bytes of a meter frame arrive on in_i (valid/ready), one word per
// cycle, with last_byte set on the final (checksum) byte. A frame is eight
// data bytes plus the checksum byte. Each word whose last_byte is set gives
// one decoded result word on res_o (valid/ready); other words give none.
// The input register holds each word; the final word of a frame is decoded
// combinationally from it and written into the result register once that
// register is free, and res_o shows the result from the result register.
// Throughput: one word per cycle, sustained, while res_o is taken on time.
// The result register frees the input side: non-final words keep flowing
// while a result waits; a final word waits in the input register only when
// the result register is still full and res_o.ready is low, and in_i.ready
// then drops.
// Reset (rst_ni low, asynchronous) empties both registers, clears the byte
// count and sum, the kept mode and kind bits, and sets the kept digits to
// blank symbols.
`default_nettype none

module meter_lcd_frame_decoder
  import mlfd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mlfd_in_if.sink    in_i,
  mlfd_out_if.source res_o
);

  frame_t frame;
  logic   advance;

  mlfd_capture u_capture (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .frame_o   (frame)
  );

  mlfd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .frame_i   (frame),
    .advance_o (advance),
    .out_o     (res_o)
  );

  a_finish_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && frame.last |=> res_o.valid)
    else $error("final word consumed without a result");

  a_finish_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && frame.last |=> frame.count == '0 && frame.sum == '0)
    else $error("byte count or sum not cleared after final word");

  a_bad_length_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.length_ok |-> res_o.unit_flags == '0 &&
      res_o.point_position == '0 && !res_o.digit_error && !res_o.checksum_ok)
    else $error("flags not zero on wrong frame length");

  a_cont_matches_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.continuity == (res_o.mode_code == ContMode))
    else $error("continuity disagrees with mode");

endmodule

`default_nettype wire

// ===== tb/meter_lcd_frame_decoder_tb.sv =====
// Self-checking testbench for the meter LCD frame decoder: directed table, then random frames.
`timescale 1ns / 1ps

module meter_lcd_frame_decoder_tb;
  import mlfd_pkg::*;

  localparam int RandomWords   = 1400;
  localparam int HoldOffCycles = 100;
  localparam int TimeoutNs     = 500_000;
  localparam int TailCycles    = 6;
  localparam int PrintCap      = 40;

  // Segment patterns after masking; the index is the symbol code (last one is blank)
  localparam logic [7:0] SegGlyphs [23] = '{
    8'd215, 8'd80,  8'd181, 8'd241, 8'd114, 8'd227, 8'd231, 8'd81,
    8'd247, 8'd243, 8'd39,  8'd55,  8'd167, 8'd135, 8'd134, 8'd118,
    8'd6,   8'd102, 8'd36,  8'd166, 8'd100, 8'd32,  8'd0
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       literal;
    result_t    want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  mlfd_in_if  byte_if ();
  mlfd_out_if frame_if ();

  meter_lcd_frame_decoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .res_o  (frame_if)
  );

  // Frame decode predictor state
  logic [3:0]  pr_count  = '0;
  logic [7:0]  pr_sum    = '0;
  logic [7:0]  pr_bytes [8];
  logic [7:0]  pr_mode   = '0;
  logic [19:0] pr_digits = DigitsBlank;
  logic [8:0]  pr_kind   = '0;

  result_t   expected_frames [$];
  stim_row_t directed_rows [$];

  logic [7:0] held_unit   = '0;
  logic [7:0] held_range  = '0;
  logic [7:0] held_status = '0;
  bit         send_calm   = 1'b0;
  bit         recv_calm   = 1'b0;

  int words_sent    = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int frames_full   = 0;
  int frames_badlen = 0;
  int digit_faults  = 0;
  int csum_fails    = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #(TimeoutNs);
    $display("timeout: %0d results still expected", expected_frames.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [4:0] lcd_symbol(input logic [7:0] pat);
    logic [4:0] code;
    code = SymUnknown;
    for (int i = 0; i < 23; i++) begin
      if ((pat & SegMask) == SegGlyphs[i]) code = 5'(i);
    end
    return code;
  endfunction

  // Advances the predictor by one word; returns 1 when the word closes a frame
  function automatic bit predict_word(input logic [7:0] b, input logic last,
                                      output result_t r);
    logic [4:0] sym;
    logic [8:0] kind;
    r = '0;
    if (!last) begin
      if (pr_count < CountFull) begin
        pr_bytes[pr_count[2:0]] = b;
        pr_sum = pr_sum + b;
      end
      if (pr_count < CountMax) pr_count = pr_count + 4'd1;
      return 1'b0;
    end
    if (pr_count == CountFull) begin
      pr_mode        = pr_bytes[0];
      r.unit_flags   = pr_bytes[1];
      r.range_flags  = pr_bytes[2];
      r.status_flags = pr_bytes[7];
      r.length_ok    = 1'b1;
      for (int k = 0; k < 4; k++) begin
        sym = lcd_symbol(pr_bytes[3 + k]);
        if (sym == SymUnknown) r.digit_error = 1'b1;
        pr_digits[5 * k +: 5] = sym;
        if (k < 3) begin
          if (pr_bytes[3 + k][3]) r.point_position = r.point_position + 3'(k + 1);
        end else begin
          r.max_flag = pr_bytes[6][3];
        end
      end
      r.checksum_ok = (b == 8'(pr_sum + CsumBias));
    end
    // A, dBm, F, Diode, tilde, hFE, Hz, Ohms, V
    kind = {r.unit_flags[1], r.unit_flags[6], r.unit_flags[7], r.range_flags[2],
            r.status_flags[2], r.status_flags[6], r.unit_flags[3], r.range_flags[5],
            r.unit_flags[2]};
    r.kind_changed = (kind != pr_kind);
    pr_kind        = kind;
    r.mode_code    = pr_mode;
    r.continuity   = (pr_mode == ContMode);
    r.digit_codes  = pr_digits;
    pr_count = '0;
    pr_sum   = '0;
    return 1'b1;
  endfunction

  function automatic result_t frame_result(logic [7:0] mode, logic [7:0] unit,
      logic [7:0] rng, logic [7:0] status, logic [19:0] digits, logic [2:0] point,
      logic maxf, logic csum, logic cont, logic changed, logic lenok, logic derr);
    return {mode, unit, rng, status, digits, point, maxf, csum, cont, changed, lenok, derr};
  endfunction

  function automatic void add_row(logic [7:0] data, logic last, logic literal = 1'b0,
                                  result_t want = '0);
    directed_rows.push_back({data, last, literal, want});
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PrintCap) $display("%0t ns result %0d: %s", $time, results_seen, msg);
  endtask

  task automatic cmp_field(string name, logic [19:0] got, logic [19:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic check_frame(result_t got);
    result_t want;
    if (expected_frames.size() == 0) begin
      report_mismatch("result word with nothing expected");
      results_seen++;
      return;
    end
    want = expected_frames.pop_front();
    cmp_field("mode_code", 20'(got.mode_code), 20'(want.mode_code));
    cmp_field("unit_flags", 20'(got.unit_flags), 20'(want.unit_flags));
    cmp_field("range_flags", 20'(got.range_flags), 20'(want.range_flags));
    cmp_field("status_flags", 20'(got.status_flags), 20'(want.status_flags));
    cmp_field("digit_codes", got.digit_codes, want.digit_codes);
    cmp_field("point_position", 20'(got.point_position), 20'(want.point_position));
    cmp_field("max_flag", 20'(got.max_flag), 20'(want.max_flag));
    cmp_field("checksum_ok", 20'(got.checksum_ok), 20'(want.checksum_ok));
    cmp_field("continuity", 20'(got.continuity), 20'(want.continuity));
    cmp_field("kind_changed", 20'(got.kind_changed), 20'(want.kind_changed));
    cmp_field("length_ok", 20'(got.length_ok), 20'(want.length_ok));
    cmp_field("digit_error", 20'(got.digit_error), 20'(want.digit_error));
    if (want.length_ok) frames_full++;
    else frames_badlen++;
    if (want.digit_error) digit_faults++;
    if (want.length_ok && !want.checksum_ok) csum_fails++;
    results_seen++;
  endtask

  // Offers one word; valid stays high across back-to-back words
  task automatic send_word(input logic [7:0] b, input logic last, input logic literal,
                           input result_t want);
    int      gap;
    bit      closes;
    result_t predicted;
    gap = send_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.last_byte <= last;
    do @(posedge clk_i); while (byte_if.ready !== 1'b1);
    closes = predict_word(b, last, predicted);
    if (closes) expected_frames.push_back(literal ? want : predicted);
    words_sent++;
  endtask

  task automatic send_random_frame();
    logic [7:0] fb [8];
    logic [7:0] sum;
    int         len;
    send_calm = ($urandom_range(0, 5) == 0);
    if ($urandom_range(0, 9) < 8) begin
      fb[0] = ($urandom_range(0, 3) == 0) ? ContMode : 8'($urandom);
      // reuse the flags now and then so the kind often stays the same
      if ($urandom_range(0, 2) == 0) begin
        fb[1] = held_unit;
        fb[2] = held_range;
        fb[7] = held_status;
      end else begin
        fb[1] = 8'($urandom);
        fb[2] = 8'($urandom);
        fb[7] = 8'($urandom);
      end
      held_unit   = fb[1];
      held_range  = fb[2];
      held_status = fb[7];
      for (int k = 3; k < 7; k++) begin
        if ($urandom_range(0, 4) == 0) fb[k] = 8'($urandom);
        else fb[k] = SegGlyphs[$urandom_range(0, 22)] | {4'd0, 1'($urandom), 3'd0};
      end
      sum = '0;
      for (int k = 0; k < 8; k++) begin
        sum = sum + fb[k];
        send_word(fb[k], 1'b0, 1'b0, '0);
      end
      if ($urandom_range(0, 3) == 0) send_word(8'($urandom), 1'b1, 1'b0, '0);
      else send_word(8'(sum + CsumBias), 1'b1, 1'b0, '0);
    end else begin
      // wrong length, from empty up to past the count saturation
      len = $urandom_range(0, 18);
      if (len == 8) len = 9;
      repeat (len) send_word(8'($urandom), 1'b0, 1'b0, '0);
      send_word(8'($urandom), 1'b1, 1'b0, '0);
    end
  endtask

  initial begin : result_sink
    int      stall;
    result_t got;
    frame_if.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (results_seen % 10 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      // long hold-offs let the result register fill and back up the input
      if (results_seen == 20 || results_seen == 90) stall = HoldOffCycles;
      else stall = recv_calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        frame_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      frame_if.ready <= 1'b1;
      do @(posedge clk_i); while (frame_if.valid !== 1'b1);
      got = {frame_if.mode_code, frame_if.unit_flags, frame_if.range_flags,
             frame_if.status_flags, frame_if.digit_codes, frame_if.point_position,
             frame_if.max_flag, frame_if.checksum_ok, frame_if.continuity,
             frame_if.kind_changed, frame_if.length_ok, frame_if.digit_error};
      check_frame(got);
    end
  end

  initial begin : stimulus
    stim_row_t row;
    rst_ni            <= 1'b0;
    byte_if.valid     <= 1'b0;
    byte_if.data_byte <= '0;
    byte_if.last_byte <= 1'b0;

    // lone final word straight after reset: wrong length, blank digits
    add_row(8'h00, 1'b1, 1'b1, frame_result(8'd0, 8'd0, 8'd0, 8'd0, DigitsBlank, 3'd0,
                                            1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    // all segments and points lit, continuity mode, good checksum
    add_row(ContMode, 1'b0);
    for (int i = 0; i < 7; i++) add_row(8'hFF, 1'b0);
    add_row(8'd70, 1'b1, 1'b1, frame_result(ContMode, 8'hFF, 8'hFF, 8'hFF, {4{5'd8}},
                                            3'd6, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
    // unknown and blank segments, point on the third digit, bad checksum
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h01, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h08, 1'b0);
    add_row(8'h09, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'hFF, 1'b1, 1'b1,
            frame_result(8'd0, 8'd0, 8'd0, 8'd0, {SymUnknown, SymBlank, SymBlank, SymUnknown},
                         3'd3, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
    // overlong frame: mode and digits must be kept
    add_row(ContMode, 1'b0);
    for (int i = 0; i < 8; i++) add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b1);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_word(row.data, row.last, row.literal, row.want);
    end
    while (words_sent < directed_rows.size() + RandomWords) send_random_frame();
    byte_if.valid <= 1'b0;

    while (expected_frames.size() > 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("%0d bytes in, %0d frames out: %0d nine-byte, %0d wrong length",
             words_sent, results_seen, frames_full, frames_badlen);
    $display("%0d with unknown segments, %0d with bad checksum, %0d mismatches",
             digit_faults, csum_fails, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
